/* design/adsr_pkg.sv */
`default_nettype none
package adsr_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int LEN_W_MAX  = 15;
    localparam int GAIN_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_W      = 31;
    localparam int QUO_W      = 16;

    localparam int MAX_NOTE_LEN_DEF = 16384;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [LEN_W_MAX-1:0] POS_MAX = 15'h7fff;
    localparam logic [GAIN_W-1:0]    ONE_Q15 = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME  = 3'd4;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_ENV,
        B_VOL
    } back_state_t;

    typedef struct packed {
        logic [LEN_W_MAX-1:0] attack_len;
        logic [LEN_W_MAX-1:0] decay_len;
        logic [GAIN_W-1:0]    sustain_level;
        logic [LEN_W_MAX-1:0] release_len;
    } env_cfg_t;

    // One classified sample: gain is num / den when use_div, else num[15:0]
    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample;
        phase_t               phase;
        logic                 use_div;
        logic [NUM_W-1:0]     num;
        logic [LEN_W_MAX-1:0] den;
    } env_item_t;

    // Centre the sample, scale by a Q1.15 gain, round half away from zero, saturate.
    function automatic logic [SAMPLE_W-1:0] scale_u8(input logic [SAMPLE_W-1:0] s,
                                                     input logic [GAIN_W-1:0]   g);
        logic signed [9:0]  c;
        logic signed [26:0] y;
        logic [26:0]        r;
        logic [SAMPLE_W-1:0] q;
        c = $signed({1'b0, s, 1'b0}) - 10'sd255;
        y = 27'sd8355840 + c * $signed({1'b0, g});
        r = unsigned'(y) + 27'd32768;
        if (y <= 27'sd0)
            q = '0;
        else if (r[26:16] > 11'd255)
            q = 8'd255;
        else
            q = r[23:16];
        return q;
    endfunction

endpackage
`default_nettype wire

/* design/adsr_front.sv */
`default_nettype none
module adsr_front #(
    parameter int MAX_NOTE_LEN = adsr_pkg::MAX_NOTE_LEN_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire [adsr_pkg::SAMPLE_W-1:0]   sample_in,
    input  wire [adsr_pkg::LEN_W_MAX-1:0]  note_len,
    input  wire                            first_of_note,
    input  adsr_pkg::env_cfg_t             cfg,
    output logic                           push_valid,
    input  wire                            push_ready,
    output adsr_pkg::env_item_t            push_item
);
    import adsr_pkg::*;

    localparam int LEN_W = (MAX_NOTE_LEN >= 32767) ? LEN_W_MAX : $clog2(MAX_NOTE_LEN + 1);

    logic [LEN_W_MAX-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]     len_reg, len_next;

    logic [LEN_W-1:0]     len_clamp;
    logic [LEN_W_MAX-1:0] idx, len15, rs, t, mul_a;
    logic [LEN_W_MAX:0]   att_dec;
    logic                 in_att, in_dec, in_sus, in_rel;
    logic [NUM_W-1:0]     prod;
    logic                 accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        if ({2'b00, note_len} > 17'(MAX_NOTE_LEN))
            len_clamp = LEN_W'(MAX_NOTE_LEN);
        else
            len_clamp = LEN_W'(note_len);
    end

    assign idx   = first_of_note ? '0 : pos_reg;
    assign len_next = first_of_note ? len_clamp : len_reg;
    assign len15 = LEN_W_MAX'(len_next);
    assign rs    = (cfg.release_len <= len15) ? (len15 - cfg.release_len) : '0;

    assign att_dec = {1'b0, cfg.attack_len} + {1'b0, cfg.decay_len};
    assign in_att  = (idx < cfg.attack_len) && (idx < rs);
    assign in_dec  = ({1'b0, idx} < att_dec) && (idx < rs);
    assign in_sus  = idx < rs;
    assign in_rel  = idx < len15;

    assign t     = idx - cfg.attack_len;
    assign mul_a = in_dec ? t : (len15 - idx);
    assign prod  = NUM_W'(mul_a * cfg.sustain_level);

    always_comb
    begin
        push_item.sample  = sample_in;
        push_item.phase   = PH_RELEASE;
        push_item.use_div = 1'b0;
        push_item.num     = '0;
        push_item.den     = cfg.decay_len;
        if (in_att)
        begin
            push_item.phase   = PH_ATTACK;
            push_item.use_div = 1'b1;
            push_item.num     = NUM_W'({idx, 15'b0});
            push_item.den     = cfg.attack_len;
        end
        else if (in_dec)
        begin
            push_item.phase   = PH_DECAY;
            push_item.use_div = 1'b1;
            push_item.num     = NUM_W'({cfg.decay_len - t, 15'b0}) + prod;
        end
        else if (in_sus)
        begin
            push_item.phase = PH_SUSTAIN;
            push_item.num   = NUM_W'(cfg.sustain_level);
        end
        else if (in_rel)
        begin
            push_item.use_div = 1'b1;
            push_item.num     = prod;
            push_item.den     = cfg.release_len;
        end
    end

    assign pos_next = (idx < POS_MAX) ? (idx + 15'd1) : idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

endmodule
`default_nettype wire

/* design/adsr_queue.sv */
`default_nettype none
module adsr_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_valid,
    output logic                 wr_ready,
    input  adsr_pkg::env_item_t  wr_item,
    output logic                 rd_valid,
    input  wire                  rd_ready,
    output adsr_pkg::env_item_t  rd_item
);
    import adsr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    env_item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_wr, do_rd;

    assign wr_ready = cnt_reg != CNT_W'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule
`default_nettype wire

/* design/adsr_back.sv */
`default_nettype none
module adsr_back (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           rd_valid,
    output logic                          rd_ready,
    input  adsr_pkg::env_item_t           rd_item,
    input  wire [adsr_pkg::GAIN_W-1:0]    volume_gain,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [adsr_pkg::SAMPLE_W-1:0] sample_out,
    output logic [1:0]                    env_phase
);
    import adsr_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    back_state_t          state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [LEN_W_MAX-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [LEN_W_MAX-1:0] den_reg;
    logic [SAMPLE_W-1:0]  sample_reg, shaped_reg;
    phase_t               phase_reg;
    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  out_sample_reg;
    logic [1:0]           out_phase_reg;

    logic                 load, div_step, env_en, vol_en, out_free;
    logic [LEN_W_MAX:0]   trial;
    logic                 fits;
    logic [SAMPLE_W-1:0]  scl_s, scl_q;
    logic [GAIN_W-1:0]    scl_g;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (rd_valid)
                    state_next = rd_item.use_div ? B_DIV : B_ENV;
            B_DIV:
                if (step_reg == STEP_W'(QUO_W - 1))
                    state_next = B_ENV;
            B_ENV:
                state_next = B_VOL;
            B_VOL:
                if (out_free)
                    state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        rd_ready = 1'b0;
        load     = 1'b0;
        div_step = 1'b0;
        env_en   = 1'b0;
        vol_en   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                rd_ready = 1'b1;
                load     = rd_valid;
            end
            B_DIV:
                div_step = 1'b1;
            B_ENV:
                env_en = 1'b1;
            B_VOL:
                vol_en = out_free;
            default:
                rd_ready = 1'b0;
        endcase
    end

    // one restoring divide step: shift in the next numerator bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        if (load)
        begin
            rem_next  = rd_item.use_div ? rd_item.num[NUM_W-1:QUO_W] : '0;
            quo_next  = rd_item.num[QUO_W-1:0];
            step_next = '0;
        end
        else if (div_step)
        begin
            rem_next  = fits ? LEN_W_MAX'(trial - {1'b0, den_reg}) : LEN_W_MAX'(trial);
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            step_next = step_reg + 1'b1;
        end
    end

    // shared scaler: envelope gain first, then track volume
    assign scl_s = env_en ? sample_reg : shaped_reg;
    assign scl_g = env_en ? quo_reg : volume_gain;
    assign scl_q = scale_u8(scl_s, scl_g);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (vol_en)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        if (load)
        begin
            den_reg    <= rd_item.den;
            sample_reg <= rd_item.sample;
            phase_reg  <= rd_item.phase;
        end
        if (env_en)
            shaped_reg <= scl_q;
        if (vol_en)
        begin
            out_sample_reg <= scl_q;
            out_phase_reg  <= phase_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign env_phase  = out_phase_reg;

endmodule
`default_nettype wire

/* design/adsr_envelope_volume.sv */
// Channel  | Direction | Handshake          | Payload
// s_*      | in        | s_tvalid/s_tready  | s_tdata: sample_in, note_len; s_tuser: first_of_note
// m_*      | out       | m_tvalid/m_tready  | m_tdata: sample_out; m_tuser: env_phase
// cfg_*    | in        | cfg_we (no wait)   | cfg_index, cfg_data
//
// A sample is classified in the cycle it is accepted and queued (two entries).
// In attack, decay or release the back end runs each sample through the radix-2 gain
// divider before the envelope and volume scaling; in sustain or past note end it skips the divider.
// The result register frees the back end: it starts the next sample while a result waits.
// Reset clears position, note length, queue and result valid; there is no clearing pass.
// A stalled m_tready holds the result; s_tready drops only when the queue is full.
`default_nettype none
module adsr_envelope_volume #(
    parameter int MAX_NOTE_LEN = adsr_pkg::MAX_NOTE_LEN_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [23:0]                       s_tdata,   // sample_in[7:0], note_len[22:8], pad
    input  wire [0:0]                        s_tuser,   // first_of_note[0]
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // sample_out[7:0]
    output logic [1:0]                       m_tuser,   // env_phase[1:0]
    input  wire                              cfg_we,
    input  wire [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [adsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adsr_pkg::*;

    env_cfg_t          cfg_reg;
    logic [GAIN_W-1:0] volume_reg;

    logic              q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    env_item_t         q_wr_item, q_rd_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_len    <= '0;
            cfg_reg.decay_len     <= '0;
            cfg_reg.sustain_level <= ONE_Q15;
            cfg_reg.release_len   <= '0;
            volume_reg            <= ONE_Q15;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK:  cfg_reg.attack_len    <= cfg_data[LEN_W_MAX-1:0];
                REG_DECAY:   cfg_reg.decay_len     <= cfg_data[LEN_W_MAX-1:0];
                REG_SUSTAIN: cfg_reg.sustain_level <= cfg_data;
                REG_RELEASE: cfg_reg.release_len   <= cfg_data[LEN_W_MAX-1:0];
                REG_VOLUME:  volume_reg            <= cfg_data;
                default:     volume_reg            <= volume_reg;
            endcase
        end
    end

    adsr_front #(
        .MAX_NOTE_LEN (MAX_NOTE_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .sample_in     (s_tdata[7:0]),
        .note_len      (s_tdata[22:8]),
        .first_of_note (s_tuser[0]),
        .cfg           (cfg_reg),
        .push_valid    (q_wr_valid),
        .push_ready    (q_wr_ready),
        .push_item     (q_wr_item)
    );

    adsr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (q_wr_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_item  (q_rd_item)
    );

    adsr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_valid    (q_rd_valid),
        .rd_ready    (q_rd_ready),
        .rd_item     (q_rd_item),
        .volume_gain (volume_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .sample_out  (m_tdata),
        .env_phase   (m_tuser)
    );

endmodule
`default_nettype wire

/* design/adsr_chk.sv */
`default_nettype none
module adsr_chk (
    input wire       clk,
    input wire       rst_n,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire [1:0] m_tuser
);
    import adsr_pkg::*;

    // queue entries, one in the back end, one in the result register
    localparam int MAX_FLIGHT = QUEUE_DEPTH + 2;
    localparam int FL_W       = $clog2(MAX_FLIGHT + 2);

    logic [FL_W-1:0] flight_reg, flight_next;
    logic            in_acc, out_acc;

    assign in_acc      = s_tvalid && s_tready;
    assign out_acc     = m_tvalid && m_tready;
    assign flight_next = flight_reg + FL_W'(in_acc) - FL_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else
            flight_reg <= flight_next;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> flight_reg != '0)
        else $error("result without a pending request");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= FL_W'(MAX_FLIGHT))
        else $error("more requests in flight than the block can hold");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind adsr_envelope_volume adsr_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
